// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define BBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define BBD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/bbd_pkg.sv =====
// ----------------------------------------------------------------------------
// bbd_pkg
// codes, widths and types of the banked bus decoder
// ----------------------------------------------------------------------------
`default_nettype none

package bbd_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned TGT_W  = 4;
  localparam int unsigned OFF_W  = 19;
  localparam int unsigned ERR_W  = 2;

  // bus functions
  localparam logic [FUNC_W-1:0] FUNC_MEM_RD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MEM_WR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_IO_RD  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_IO_WR  = 2'd3;

  // memory map
  localparam logic [ADDR_W-1:0] WIN_BASE  = 16'h4000;
  localparam logic [ADDR_W-1:0] RAM_START = 16'h8000;
  localparam logic [ADDR_W-1:0] EEP_START = 16'hE000;
  localparam int unsigned       WIN_OFF_W = 14;

  // io ports
  localparam logic [ADDR_W-1:0] PORT_SND1_LATCH = 16'd0;
  localparam logic [ADDR_W-1:0] PORT_SND1_DATA  = 16'd1;
  localparam logic [ADDR_W-1:0] PORT_SND2_LATCH = 16'd2;
  localparam logic [ADDR_W-1:0] PORT_SND2_DATA  = 16'd3;
  localparam logic [ADDR_W-1:0] PORT_VIDEO0     = 16'd4;
  localparam logic [ADDR_W-1:0] PORT_VIDEO1     = 16'd5;
  localparam logic [ADDR_W-1:0] PORT_VIDEO2     = 16'd6;
  localparam logic [ADDR_W-1:0] PORT_VIDEO3     = 16'd7;
  localparam logic [ADDR_W-1:0] PORT_UART       = 16'd8;

  // targets
  localparam logic [TGT_W-1:0] TGT_FLASH  = 4'd0;
  localparam logic [TGT_W-1:0] TGT_RAM    = 4'd1;
  localparam logic [TGT_W-1:0] TGT_EEPROM = 4'd2;
  localparam logic [TGT_W-1:0] TGT_BANK   = 4'd3;
  localparam logic [TGT_W-1:0] TGT_SND1L  = 4'd4;
  localparam logic [TGT_W-1:0] TGT_SND1D  = 4'd5;
  localparam logic [TGT_W-1:0] TGT_SND2L  = 4'd6;
  localparam logic [TGT_W-1:0] TGT_SND2D  = 4'd7;
  localparam logic [TGT_W-1:0] TGT_VIDEO  = 4'd8;
  localparam logic [TGT_W-1:0] TGT_UART   = 4'd9;
  localparam logic [TGT_W-1:0] TGT_NONE   = 4'd10;

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_WRITEONLY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NOPORT    = 2'd2;
  localparam logic [ERR_W-1:0] ERR_INDEX     = 2'd3;

  // decoded result without the read data
  typedef struct packed {
    logic [TGT_W-1:0]  target;
    logic [OFF_W-1:0]  offset;
    logic [DATA_W-1:0] fwd_data;
    logic [ERR_W-1:0]  error;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/bbd_ram.sv =====
// ----------------------------------------------------------------------------
// bbd_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module bbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/banked_bus_decoder_core.sv =====
// ----------------------------------------------------------------------------
// banked_bus_decoder_core
// bus decoder with flash bank latch and two sound register files
// ----------------------------------------------------------------------------
// One bus access is taken per cycle while the output side is not stalled. The
// access is decoded and the sound register ram access issued in the accepting
// cycle, the next stage holds the decode while the ram read data arrives, and
// an output register then frees the input side while a result waits; the
// result is on the outputs once it is in the output register. The two sound
// register files share one synchronous ram with a registered read; entries
// carry reset-cleared valid bits so unwritten registers read as zero, with no
// clearing pass after reset.
`default_nettype none

module banked_bus_decoder_core
  import bbd_pkg::*;
#(
  parameter int unsigned SOUND_REGS  = 14,
  parameter int unsigned FLASH_BANKS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      logic [TGT_W-1:0]  target_o,
  output      logic [OFF_W-1:0]  offset_o,
  output      logic [DATA_W-1:0] rdata_o,
  output      logic [DATA_W-1:0] fwd_data_o,
  output      logic [ERR_W-1:0]  error_o
);

`include "assert_macros.svh"

  localparam int unsigned SIDX_W    = (SOUND_REGS > 1) ? $clog2(SOUND_REGS) : 1;
  localparam int unsigned RAM_AW    = SIDX_W + 1;
  localparam int unsigned RAM_DEPTH = 2 ** RAM_AW;
  localparam int unsigned BANK_W    = $clog2(FLASH_BANKS);
  localparam int unsigned WIN_W     = BANK_W + WIN_OFF_W;
  localparam int unsigned NUM_BYTES = 2 ** DATA_W;

  // architectural latches
  logic [BANK_W-1:0] bank_q, bank_d;
  logic [DATA_W-1:0] snd1_idx_q, snd1_idx_d;
  logic [DATA_W-1:0] snd2_idx_q, snd2_idx_d;
  logic [RAM_DEPTH-1:0] vld_q, vld_d;

  // pipeline
  logic          a_valid_q, a_valid_d;
  res_t          a_res_q, a_res_d;
  logic          a_rd_q, a_rd_d;
  logic          b_valid_q, b_valid_d;
  res_t          b_res_q;
  logic [DATA_W-1:0] b_rdata_q;

  logic              accept;
  logic              advance_a;
  logic              is_wr;
  logic              snd_sel;
  logic [DATA_W-1:0] snd_idx;
  logic              idx_ok;
  logic [RAM_AW-1:0] ram_addr;
  logic              ram_we;
  logic              ram_re;
  logic [DATA_W-1:0] ram_rdata;
  logic [WIN_W-1:0]  win_full;
  logic [DATA_W-1:0] fwd_wr;

  // bank number reduced modulo the bank count
  logic [BANK_W-1:0] bank_mod_tbl [NUM_BYTES];

  for (genvar g = 0; g < NUM_BYTES; g++) begin : g_bank_tbl
    assign bank_mod_tbl[g] = BANK_W'(g % FLASH_BANKS);
  end

  // handshake
  assign advance_a  = a_valid_q & (~b_valid_q | out_ready_i);
  assign in_ready_o = ~a_valid_q | advance_a;
  assign accept     = in_valid_i & in_ready_o;

  // sound data port selection
  assign is_wr    = func_i[0];
  assign snd_sel  = (addr_i == PORT_SND2_DATA);
  assign snd_idx  = snd_sel ? snd2_idx_q : snd1_idx_q;
  assign idx_ok   = (snd_idx < DATA_W'(SOUND_REGS));
  assign ram_addr = {snd_sel, snd_idx[SIDX_W-1:0]};
  assign win_full = {bank_q, addr_i[WIN_OFF_W-1:0]};
  assign fwd_wr   = is_wr ? wdata_i : '0;

  // access decode
  always_comb begin
    a_res_d.target   = TGT_NONE;
    a_res_d.offset   = '0;
    a_res_d.fwd_data = '0;
    a_res_d.error    = ERR_OK;
    a_rd_d           = 1'b0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    bank_d           = bank_q;
    snd1_idx_d       = snd1_idx_q;
    snd2_idx_d       = snd2_idx_q;
    if (func_i == FUNC_MEM_RD || func_i == FUNC_MEM_WR) begin
      a_res_d.fwd_data = fwd_wr;
      if (is_wr && addr_i < RAM_START) begin
        a_res_d.target = TGT_BANK;
        bank_d         = bank_mod_tbl[wdata_i];
      end else if (addr_i < WIN_BASE) begin
        a_res_d.target = TGT_FLASH;
        a_res_d.offset = OFF_W'(addr_i);
      end else if (addr_i < RAM_START) begin
        a_res_d.target = TGT_FLASH;
        a_res_d.offset = OFF_W'(win_full);
      end else if (addr_i < EEP_START) begin
        a_res_d.target = TGT_RAM;
        a_res_d.offset = OFF_W'(addr_i - RAM_START);
      end else begin
        a_res_d.target = TGT_EEPROM;
        a_res_d.offset = OFF_W'(addr_i - EEP_START);
      end
    end else begin
      case (addr_i)
        PORT_SND1_LATCH, PORT_SND2_LATCH: begin
          a_res_d.target = (addr_i == PORT_SND1_LATCH) ? TGT_SND1L : TGT_SND2L;
          if (is_wr) begin
            a_res_d.offset   = OFF_W'(wdata_i);
            a_res_d.fwd_data = wdata_i;
            if (addr_i == PORT_SND1_LATCH) begin
              snd1_idx_d = wdata_i;
            end else begin
              snd2_idx_d = wdata_i;
            end
          end else begin
            a_res_d.error = ERR_WRITEONLY;
          end
        end
        PORT_SND1_DATA, PORT_SND2_DATA: begin
          a_res_d.target   = snd_sel ? TGT_SND2D : TGT_SND1D;
          a_res_d.offset   = OFF_W'(snd_idx);
          a_res_d.fwd_data = fwd_wr;
          if (!idx_ok) begin
            a_res_d.error = ERR_INDEX;
          end else if (is_wr) begin
            ram_we = 1'b1;
          end else begin
            ram_re = 1'b1;
            a_rd_d = vld_q[ram_addr];
          end
        end
        PORT_VIDEO0, PORT_VIDEO1, PORT_VIDEO2, PORT_VIDEO3: begin
          a_res_d.target   = TGT_VIDEO;
          a_res_d.offset   = OFF_W'(addr_i - PORT_VIDEO0);
          a_res_d.fwd_data = fwd_wr;
        end
        PORT_UART: begin
          a_res_d.target   = TGT_UART;
          a_res_d.fwd_data = fwd_wr;
          if (!is_wr) begin
            a_res_d.error = ERR_WRITEONLY;
          end
        end
        default: begin
          a_res_d.error = ERR_NOPORT;
        end
      endcase
    end
  end

  // entry valid bits
  always_comb begin
    vld_d = vld_q;
    if (accept && ram_we) begin
      vld_d[ram_addr] = 1'b1;
    end
  end

  // sound register ram
  bbd_ram #(
    .WIDTH(DATA_W),
    .DEPTH(RAM_DEPTH)
  ) u_snd_ram (
    .clk_i  (clk_i),
    .we_i   (accept & ram_we),
    .re_i   (accept & ram_re),
    .addr_i (ram_addr),
    .wdata_i(wdata_i),
    .rdata_o(ram_rdata)
  );

  // stage valids
  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (advance_a) begin
      a_valid_d = 1'b0;
    end
    b_valid_d = b_valid_q;
    if (advance_a) begin
      b_valid_d = 1'b1;
    end else if (out_ready_i) begin
      b_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q  <= 1'b0;
      b_valid_q  <= 1'b0;
      bank_q     <= '0;
      snd1_idx_q <= '0;
      snd2_idx_q <= '0;
      vld_q      <= '0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
      vld_q     <= vld_d;
      if (accept) begin
        bank_q     <= bank_d;
        snd1_idx_q <= snd1_idx_d;
        snd2_idx_q <= snd2_idx_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_res_q <= a_res_d;
      a_rd_q  <= a_rd_d;
    end
    if (advance_a) begin
      b_res_q   <= a_res_q;
      b_rdata_q <= a_rd_q ? ram_rdata : '0;
    end
  end

  // result ports
  assign out_valid_o = b_valid_q;
  assign target_o    = b_res_q.target;
  assign offset_o    = b_res_q.offset;
  assign rdata_o     = b_rdata_q;
  assign fwd_data_o  = b_res_q.fwd_data;
  assign error_o     = b_res_q.error;

  // checks
  `BBD_ASSERT(a_rdata_src, out_valid_o && rdata_o != '0 |-> (target_o == TGT_SND1D || target_o == TGT_SND2D) && error_o == ERR_OK, "read data on a non sound result")
  `BBD_ASSERT(a_full_stall, a_valid_q && b_valid_q && !out_ready_i |-> !in_ready_o, "beat taken while both stages are stalled")
  `BBD_ASSERT(a_idx_err, out_valid_o && error_o == ERR_INDEX |-> offset_o >= OFF_W'(SOUND_REGS), "index error with an index in range")
  `BBD_ASSERT(a_bank_range, {1'b0, bank_q} < (BANK_W + 1)'(FLASH_BANKS), "bank latch out of range")

endmodule

`default_nettype wire

// ===== test/tb_banked_bus_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_banked_bus_decoder_core
// self-checking bench for the banked bus decoder
// ----------------------------------------------------------------------------
// A queue of bus accesses is filled up front. It holds a directed set that
// covers the memory map edges, the bank latch, the sound register files and
// io ports but video 1-2. Random traffic follows, mostly latch-then-data sound
// sequences mixed with memory accesses and io noise. A clocked driver feeds
// the access queue to the block with random gaps. A clocked monitor decodes
// each accepted access in a local model of the block and compares every
// result beat with the oldest pending decode. The output side stalls at
// random. Both sides run without gaps near the end.
`timescale 1ns / 1ps

module tb_banked_bus_decoder_core;
  import bbd_pkg::*;

  localparam int unsigned NUM_SND_REGS = 14;
  localparam int unsigned NUM_BANKS    = 32;
  localparam int unsigned TOTAL_BEATS  = 1775;
  localparam int unsigned TAIL_BEATS   = 150;
  localparam int unsigned STALL_LIMIT  = 2000;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    int unsigned       gap;
  } bus_beat_t;

  typedef struct packed {
    logic [TGT_W-1:0]  target;
    logic [OFF_W-1:0]  offset;
    logic [DATA_W-1:0] rdata;
    logic [DATA_W-1:0] fwd_data;
    logic [ERR_W-1:0]  error;
  } decode_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [FUNC_W-1:0] func_i      = '0;
  logic [ADDR_W-1:0] addr_i      = '0;
  logic [DATA_W-1:0] wdata_i     = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [TGT_W-1:0]  target_o;
  logic [OFF_W-1:0]  offset_o;
  logic [DATA_W-1:0] rdata_o;
  logic [DATA_W-1:0] fwd_data_o;
  logic [ERR_W-1:0]  error_o;

  bus_beat_t   access_q[$];
  decode_t     decode_q[$];
  bus_beat_t   cur_beat;
  bit          cur_held    = 1'b0;
  int unsigned tx_wait     = 0;
  bit          tx_idle_on  = 1'b1;
  bit          in_taken    = 1'b0;
  int unsigned rx_stall    = 0;
  bit          rx_stall_on = 1'b1;
  int unsigned rx_cycle    = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_cnt    = 0;
  decode_t     exp_d;

  // local copy of the decoder state
  logic [7:0] bank_sel;
  logic [7:0] snd_index [2];
  logic [7:0] snd_file  [2][NUM_SND_REGS];

  banked_bus_decoder_core #(
    .SOUND_REGS (NUM_SND_REGS),
    .FLASH_BANKS(NUM_BANKS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .addr_i     (addr_i),
    .wdata_i    (wdata_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .target_o   (target_o),
    .offset_o   (offset_o),
    .rdata_o    (rdata_o),
    .fwd_data_o (fwd_data_o),
    .error_o    (error_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // decode one access and update the local state
  function automatic decode_t decode_access(input logic [FUNC_W-1:0] fn,
                                            input logic [ADDR_W-1:0] a,
                                            input logic [DATA_W-1:0] wd);
    decode_t     d;
    logic        wr;
    int unsigned f;
    logic [7:0]  idx;
    d  = '0;
    wr = (fn == FUNC_MEM_WR) || (fn == FUNC_IO_WR);
    if (fn == FUNC_MEM_RD || fn == FUNC_MEM_WR) begin
      if (wr && a < RAM_START) begin
        // writes below ram load the bank latch
        bank_sel   = wd;
        d.target   = TGT_BANK;
        d.fwd_data = wd;
      end else if (a < WIN_BASE) begin
        d.target   = TGT_FLASH;
        d.offset   = OFF_W'(a);
        d.fwd_data = wr ? wd : '0;
      end else if (a < RAM_START) begin
        // banked window, reads only
        d.target = TGT_FLASH;
        d.offset = OFF_W'(int'(a - WIN_BASE) +
                          (int'(bank_sel) % NUM_BANKS) * int'(WIN_BASE));
      end else if (a < EEP_START) begin
        d.target   = TGT_RAM;
        d.offset   = OFF_W'(a - RAM_START);
        d.fwd_data = wr ? wd : '0;
      end else begin
        d.target   = TGT_EEPROM;
        d.offset   = OFF_W'(a - EEP_START);
        d.fwd_data = wr ? wd : '0;
      end
    end else begin
      case (a)
        PORT_SND1_LATCH, PORT_SND2_LATCH: begin
          f        = (a == PORT_SND2_LATCH);
          d.target = f ? TGT_SND2L : TGT_SND1L;
          if (wr) begin
            snd_index[f] = wd;
            d.offset     = OFF_W'(wd);
            d.fwd_data   = wd;
          end else begin
            d.error = ERR_WRITEONLY;
          end
        end
        PORT_SND1_DATA, PORT_SND2_DATA: begin
          f        = (a == PORT_SND2_DATA);
          d.target = f ? TGT_SND2D : TGT_SND1D;
          idx      = snd_index[f];
          d.offset = OFF_W'(idx);
          if (idx >= NUM_SND_REGS) begin
            // index past the register file, nothing is stored
            d.error    = ERR_INDEX;
            d.fwd_data = wr ? wd : '0;
          end else if (wr) begin
            snd_file[f][idx] = wd;
            d.fwd_data       = wd;
          end else begin
            d.rdata = snd_file[f][idx];
          end
        end
        PORT_VIDEO0, PORT_VIDEO1, PORT_VIDEO2, PORT_VIDEO3: begin
          d.target   = TGT_VIDEO;
          d.offset   = OFF_W'(a - PORT_VIDEO0);
          d.fwd_data = wr ? wd : '0;
        end
        PORT_UART: begin
          d.target = TGT_UART;
          if (wr) d.fwd_data = wd;
          else d.error = ERR_WRITEONLY;
        end
        default: begin
          d.target = TGT_NONE;
          d.error  = ERR_NOPORT;
        end
      endcase
    end
    return d;
  endfunction

  // append one access, with a random gap ahead of it
  task automatic queue_beat(input logic [FUNC_W-1:0] fn, input logic [ADDR_W-1:0] a,
                            input logic [DATA_W-1:0] wd);
    bus_beat_t b;
    if (access_q.size() % 100 == 0) tx_idle_on = ($urandom_range(0, 2) != 0);
    b.func  = fn;
    b.addr  = a;
    b.wdata = wd;
    b.gap   = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    access_q.push_back(b);
  endtask

  // one random burst: memory, a sound sequence, video or uart, or noise
  task automatic queue_random_burst();
    int unsigned kind;
    int unsigned n;
    int unsigned f;
    logic [7:0]  idx;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      queue_beat($urandom_range(0, 1) ? FUNC_MEM_WR : FUNC_MEM_RD, 16'($urandom),
                 8'($urandom));
    end else if (kind < 8) begin
      f   = $urandom_range(0, 1);
      idx = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(NUM_SND_REGS, 255))
                                        : 8'($urandom_range(0, NUM_SND_REGS - 1));
      queue_beat(FUNC_IO_WR, f ? PORT_SND2_LATCH : PORT_SND1_LATCH, idx);
      n = $urandom_range(1, 4);
      repeat (n) begin
        queue_beat($urandom_range(0, 1) ? FUNC_IO_WR : FUNC_IO_RD,
                   f ? PORT_SND2_DATA : PORT_SND1_DATA, 8'($urandom));
      end
    end else if (kind == 8) begin
      queue_beat($urandom_range(0, 1) ? FUNC_IO_WR : FUNC_IO_RD,
                 16'($urandom_range(PORT_VIDEO0, PORT_UART)), 8'($urandom));
    end else begin
      queue_beat(FUNC_W'($urandom),
                 $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 15)),
                 8'($urandom));
    end
  endtask

  // stimulus, reset and end of run
  initial begin
    bank_sel = '0;
    for (int f = 0; f < 2; f++) begin
      snd_index[f] = '0;
      for (int r = 0; r < NUM_SND_REGS; r++) snd_file[f][r] = '0;
    end

    // memory map edges and the bank latch
    queue_beat(FUNC_MEM_RD, 16'h0000, 8'h00);
    queue_beat(FUNC_MEM_RD, 16'h3FFF, 8'hFF);
    queue_beat(FUNC_MEM_RD, WIN_BASE, 8'h00);
    queue_beat(FUNC_MEM_WR, 16'h0000, 8'hFF);
    queue_beat(FUNC_MEM_RD, 16'h7FFF, 8'h00);
    queue_beat(FUNC_MEM_WR, 16'h7FFF, 8'h21);
    queue_beat(FUNC_MEM_RD, WIN_BASE, 8'h00);
    queue_beat(FUNC_MEM_RD, RAM_START, 8'h00);
    queue_beat(FUNC_MEM_WR, 16'hDFFF, 8'hA5);
    queue_beat(FUNC_MEM_RD, EEP_START, 8'h00);
    queue_beat(FUNC_MEM_WR, 16'hFFFF, 8'h5A);
    // reads of write-only ports
    queue_beat(FUNC_IO_RD, PORT_SND1_LATCH, 8'h00);
    queue_beat(FUNC_IO_RD, PORT_SND2_LATCH, 8'h00);
    queue_beat(FUNC_IO_RD, PORT_UART, 8'h00);
    // sound files, last index and out-of-range index
    queue_beat(FUNC_IO_WR, PORT_SND1_LATCH, 8'(NUM_SND_REGS - 1));
    queue_beat(FUNC_IO_WR, PORT_SND1_DATA, 8'hFF);
    queue_beat(FUNC_IO_RD, PORT_SND1_DATA, 8'h00);
    queue_beat(FUNC_IO_WR, PORT_SND2_LATCH, 8'hFF);
    queue_beat(FUNC_IO_WR, PORT_SND2_DATA, 8'h3C);
    queue_beat(FUNC_IO_RD, PORT_SND2_DATA, 8'h00);
    queue_beat(FUNC_IO_WR, PORT_SND2_LATCH, 8'h00);
    queue_beat(FUNC_IO_RD, PORT_SND2_DATA, 8'h00);
    // video, uart and undefined ports
    queue_beat(FUNC_IO_WR, PORT_VIDEO3, 8'h81);
    queue_beat(FUNC_IO_RD, PORT_VIDEO0, 8'h00);
    queue_beat(FUNC_IO_WR, PORT_UART, 8'h55);
    queue_beat(FUNC_IO_RD, 16'd9, 8'h00);
    queue_beat(FUNC_IO_WR, 16'hFFFF, 8'hFF);

    while (access_q.size() < TOTAL_BEATS) queue_random_burst();
    // no gaps in the tail
    for (int i = access_q.size() - TAIL_BEATS; i < access_q.size(); i++) access_q[i].gap = 0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // wait for all accesses, then all results, then let the pipe settle
    while (access_q.size() != 0 || cur_held || in_valid_i) @(posedge clk_i);
    while (decode_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // input driver, changes on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (!cur_held && access_q.size() != 0) begin
        cur_beat = access_q.pop_front();
        tx_wait  = cur_beat.gap;
        cur_held = 1'b1;
      end
      if (cur_held && tx_wait == 0) begin
        in_valid_i <= 1'b1;
        func_i     <= cur_beat.func;
        addr_i     <= cur_beat.addr;
        wdata_i    <= cur_beat.wdata;
        cur_held   = 1'b0;
      end else begin
        in_valid_i <= 1'b0;
        if (cur_held) tx_wait--;
      end
    end
  end

  // output back-pressure in random bursts, none in the tail
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 128 == 0) rx_stall_on = ($urandom_range(0, 2) != 0);
    if (access_q.size() < TAIL_BEATS) begin
      out_ready_i <= 1'b1;
    end else if (rx_stall > 0) begin
      out_ready_i <= 1'b0;
      rx_stall--;
    end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      rx_stall = $urandom_range(0, 8);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor: check result beats, decode accepted accesses
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (decode_q.size() == 0) begin
          $error("result beat with no access pending");
          fail_cnt++;
        end else begin
          exp_d = decode_q.pop_front();
          if (target_o !== exp_d.target) begin
            $error("target mismatch: expected %0d, actual %0d", exp_d.target, target_o);
            fail_cnt++;
          end
          if (offset_o !== exp_d.offset) begin
            $error("offset mismatch: expected %0d, actual %0d", exp_d.offset, offset_o);
            fail_cnt++;
          end
          if (rdata_o !== exp_d.rdata) begin
            $error("rdata mismatch: expected %0d, actual %0d", exp_d.rdata, rdata_o);
            fail_cnt++;
          end
          if (fwd_data_o !== exp_d.fwd_data) begin
            $error("fwd_data mismatch: expected %0d, actual %0d", exp_d.fwd_data,
                   fwd_data_o);
            fail_cnt++;
          end
          if (error_o !== exp_d.error) begin
            $error("error mismatch: expected %0d, actual %0d", exp_d.error, error_o);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_o) decode_q.push_back(decode_access(func_i, addr_i, wdata_i));
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bbd_pkg.sv
rtl/bbd_ram.sv
rtl/banked_bus_decoder_core.sv
test/tb_banked_bus_decoder_core.sv
